@@ rtl/core/hfma_pkg.sv @@
// Shared types and constants for the Hall flux moving-average block.
`default_nettype none

package hfma_pkg;

    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 16;
    localparam int FLUX_W   = 19;
    localparam int SUM_W    = 24;
    localparam int PROD_W   = 28;

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic signed [FLUX_W-1:0]   flux_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam flux_t FLUX_MAX = 19'sh3FFFF;
    localparam flux_t FLUX_MIN = 19'sh40000;

    localparam sample_t ZERO_OFFSET_RST = 10'd512;
    localparam gain_t   GAIN_Q16_RST    = 16'd42821;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic REG_ZERO_OFFSET = 1'b0;
    localparam logic REG_GAIN_Q16    = 1'b1;

    // Load strobes for the two stages of the mean divider.
    typedef struct packed {
        logic load_mul;
        logic load_out;
    } hfma_div_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/hall_flux_moving_average_top.sv @@
// Top level of the Hall sensor flux converter with boxcar moving average.
`default_nettype none

// Each input item carries one 10-bit Hall ADC sample. The block subtracts
// zero_offset, multiplies by the unsigned Q16 gain gain_q16 and shifts right by
// eight (toward minus infinity) to get flux in millitesla, signed Q8, saturated
// to 19 bits. The last WINDOW flux values sit in a ring that reset clears, with
// a running sum; each item yields one result with the raw sample, the flux and
// the window mean (sum / WINDOW, rounded toward zero). During the first WINDOW-1
// items the mean still divides by WINDOW, so cleared entries count as zero.
// The block takes one item per cycle unless the master side stalls it, and
// each item passes five registers: input register, gain multiply, ring
// update, reciprocal multiply, output register. The ring read, subtract-add
// and write-back all happen in the ring update stage, which is what holds
// the rate at one item per clock. Each stage moves on when the stage after
// it is empty or moving, so up to five items are buffered while the master
// side stalls. Registers are to be written through the APB port only while
// the block is idle; the user must keep to this, as the block does not enforce
// it. zero_offset is at address 0, gain_q16 at address 4.

module hall_flux_moving_average_top #(
    parameter int WINDOW = 25
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input stream. s_tdata: [9:0] raw_sample, [15:10] zero.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,
    // Result stream. m_tdata: [9:0] raw_echo, [28:10] flux_mt_q8,
    // [47:29] filtered_mt_q8.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hfma_pkg::*;

    // Configuration registers.
    sample_t zero_offset_reg;
    gain_t   gain_q16_reg;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg <= ZERO_OFFSET_RST;
            gain_q16_reg    <= GAIN_Q16_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ZERO_OFFSET: zero_offset_reg <= pwdata[SAMPLE_W-1:0];
                REG_GAIN_Q16:    gain_q16_reg    <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ZERO_OFFSET: prdata = 32'(zero_offset_reg);
            REG_GAIN_Q16:    prdata = 32'(gain_q16_reg);
            default:         prdata = '0;
        endcase
    end

    // Stage valid bits and load enables. A stage loads when it is empty or
    // when the stage after it loads this cycle.
    logic [4:0] v_reg;
    logic [4:0] en;

    always_comb begin
        en[4] = !v_reg[4] || m_tready;
        en[3] = !v_reg[3] || en[4];
        en[2] = !v_reg[2] || en[3];
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_tvalid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
            if (en[4]) v_reg[4] <= v_reg[3];
        end
    end

    // Stage 0: input register.
    sample_t raw0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) raw0_reg <= s_tdata[SAMPLE_W-1:0];
    end

    // Stage 1: signed offset difference times the Q16 gain.
    logic signed [SAMPLE_W:0] diff;
    prod_t diff_w;
    prod_t gain_w;
    prod_t prod_next;
    prod_t prod1_reg;
    sample_t raw1_reg;

    always_comb begin
        diff      = $signed({1'b0, raw0_reg}) - $signed({1'b0, zero_offset_reg});
        diff_w    = {{(PROD_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
        gain_w    = {{(PROD_W-GAIN_W){1'b0}}, gain_q16_reg};
        prod_next = diff_w * gain_w;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            prod1_reg <= prod_next;
            raw1_reg  <= raw0_reg;
        end
    end

    // Stage 2: drop eight fraction bits, saturate, and update the ring.
    logic signed [FLUX_W:0] shifted;
    flux_t flux_next;
    flux_t flux2_reg;
    sample_t raw2_reg;
    sum_t  window_sum;
    logic  ring_upd;

    always_comb begin
        shifted = prod1_reg[PROD_W-1:8];
        if (shifted[FLUX_W] == shifted[FLUX_W-1]) begin
            flux_next = shifted[FLUX_W-1:0];
        end else if (shifted[FLUX_W]) begin
            flux_next = FLUX_MIN;
        end else begin
            flux_next = FLUX_MAX;
        end
    end

    assign ring_upd = en[2] && v_reg[1];

    hfma_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (ring_upd),
        .flux    (flux_next),
        .sum     (window_sum)
    );

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            flux2_reg <= flux_next;
            raw2_reg  <= raw1_reg;
        end
    end

    // Stages 3 and 4: the mean divider runs beside the pass-through fields.
    // The ring's sum register is the sum after stage 2's item was added.
    hfma_div_ctl_t div_ctl;
    flux_t flux3_reg;
    flux_t flux4_reg;
    sample_t raw3_reg;
    sample_t raw4_reg;
    flux_t mean;

    assign div_ctl.load_mul = en[3];
    assign div_ctl.load_out = en[4];

    hfma_mean_div #(
        .WINDOW (WINDOW)
    ) u_mean_div (
        .aclk (aclk),
        .ctl  (div_ctl),
        .sum  (window_sum),
        .mean (mean)
    );

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            flux3_reg <= flux2_reg;
            raw3_reg  <= raw2_reg;
        end
        if (en[4]) begin
            flux4_reg <= flux3_reg;
            raw4_reg  <= raw3_reg;
        end
    end

    assign m_tdata = {mean, flux4_reg, raw4_reg};

    // An empty input stage always takes an item.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[0] |-> s_tready)
        else $error("input stage empty but not ready");

    // An accepted item occupies the input stage on the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item was lost at the input stage");

    // Input stalls only when every stage is full and the result is not taken.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v_reg == 5'h1F) && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ rtl/core/hfma_ring.sv @@
// History ring of flux values with its running window sum.
`default_nettype none

module hfma_ring #(
    parameter int WINDOW = 25
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 upd,
    input  wire hfma_pkg::flux_t flux,
    output hfma_pkg::sum_t      sum
);
    import hfma_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    flux_t             ring_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    sum_t              sum_reg;
    sum_t              sum_next;

    always_comb begin
        sum_next  = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(flux);
        slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
        end else if (upd) begin
            ring_reg[slot_reg] <= flux;
            slot_reg           <= slot_next;
            sum_reg            <= sum_next;
        end
    end

    assign sum = sum_reg;

    // The write slot never leaves the ring.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= LAST_SLOT)
        else $error("ring slot out of range");

    // Without an update the sum and slot hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd |=> $stable(sum_reg) && $stable(slot_reg))
        else $error("ring state changed without an update");

    // An update moves the slot on by one place, wrapping at the end.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        upd |=> slot_reg == $past(slot_next))
        else $error("ring slot did not advance");

endmodule

`default_nettype wire

@@ rtl/core/hfma_mean_div.sv @@
// Two-stage divide of the window sum by WINDOW, rounded toward zero.
`default_nettype none

module hfma_mean_div #(
    parameter int WINDOW = 25
) (
    input  wire                    aclk,
    input  wire hfma_pkg::hfma_div_ctl_t ctl,
    input  wire hfma_pkg::sum_t    sum,
    output hfma_pkg::flux_t        mean
);
    import hfma_pkg::*;

    // Reciprocal exact for every magnitude below 2**SUM_W.
    localparam int LOG_W = $clog2(WINDOW);
    localparam int SHIFT = SUM_W + LOG_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W = SUM_W + 1;
    localparam int MUL_W   = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic [SUM_W-1:0] mag;
    logic [MUL_W-1:0] prod_next;
    logic [MUL_W-1:0] prod_reg;
    logic             neg_reg;
    logic [MUL_W-1:0] quot_full;
    logic [SUM_W-1:0] quot;
    sum_t             mean_full;
    flux_t            mean_reg;

    always_comb begin
        mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        prod_next = MUL_W'(mag) * MUL_W'(RECIP_C);
        quot_full = prod_reg >> SHIFT;
        quot      = quot_full[SUM_W-1:0];
        mean_full = neg_reg ? -sum_t'(quot) : sum_t'(quot);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_mul) begin
            prod_reg <= prod_next;
            neg_reg  <= sum[SUM_W-1];
        end
        if (ctl.load_out) begin
            mean_reg <= mean_full[FLUX_W-1:0];
        end
    end

    assign mean = mean_reg;

endmodule

`default_nettype wire

@@ bench/hall_flux_moving_average_top_tb.sv @@
// Self-checking testbench for the Hall flux converter with boxcar moving average.
`timescale 1ns / 100ps

module hall_flux_moving_average_top_tb;

    import hfma_pkg::*;

    localparam int WIN        = 25;
    localparam int IDLE_LIMIT = 2000;
    localparam int LATENCY    = 5;
    localparam int SEG_ITEMS  = 150;

    // One result item, split into its fields.
    typedef struct {
        sample_t raw;
        flux_t   flux;
        flux_t   mean;
    } reading_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [9:0] raw_sample, [15:10] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [9:0] raw_echo, [28:10] flux, [47:29] mean
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    hall_flux_moving_average_top #(.WINDOW(WIN)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the block's registers and filter state.
    sample_t  shadow_offset = ZERO_OFFSET_RST;
    gain_t    shadow_gain   = GAIN_Q16_RST;
    flux_t    flux_ring [WIN];
    int       ring_slot     = 0;
    sum_t     ring_sum      = '0;
    reading_t pending_readings [$];

    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned samples_sent  = 0;
    int unsigned readings_seen = 0;
    int unsigned reg_writes    = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;

    initial begin
        foreach (flux_ring[i]) flux_ring[i] = '0;
    end

    // Converts one sample to flux and advances the boxcar window.
    function automatic reading_t next_reading(sample_t smp);
        longint   diff;
        longint   q8;
        reading_t r;
        diff = longint'(smp) - longint'(shadow_offset);
        q8   = (diff * longint'(shadow_gain)) >>> 8;
        if (q8 > longint'(FLUX_MAX)) q8 = longint'(FLUX_MAX);
        if (q8 < longint'(FLUX_MIN)) q8 = longint'(FLUX_MIN);
        r.raw  = smp;
        r.flux = flux_t'(q8);
        ring_sum = ring_sum - flux_ring[ring_slot] + r.flux;
        flux_ring[ring_slot] = r.flux;
        ring_slot = (ring_slot == WIN - 1) ? 0 : ring_slot + 1;
        // Signed division truncates toward zero, as the mean requires.
        r.mean = flux_t'(ring_sum / WIN);
        return r;
    endfunction

    // Monitor: checks each result, predicts each accepted sample, tracks
    // register writes, and runs the watchdog on cycles with no handshake.
    always @(posedge aclk) begin
        reading_t want;
        reading_t got;
        logic     busy;
        busy = 1'b0;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                busy = 1'b1;
                readings_seen++;
                got.raw  = m_tdata[9:0];
                got.flux = m_tdata[28:10];
                got.mean = m_tdata[47:29];
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: raw %0d flux %0d mean %0d",
                                 got.raw, got.flux, got.mean);
                end else begin
                    want = pending_readings.pop_front();
                    if (got.raw !== want.raw || got.flux !== want.flux ||
                        got.mean !== want.mean) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected raw %0d flux %0d mean %0d, %s",
                                     want.raw, want.flux, want.mean,
                                     $sformatf("got raw %0d flux %0d mean %0d",
                                               got.raw, got.flux, got.mean));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                busy = 1'b1;
                pending_readings.push_back(next_reading(s_tdata[9:0]));
            end
            if (psel && penable && pwrite && pready) begin
                busy = 1'b1;
                if (paddr[2] == REG_ZERO_OFFSET)
                    shadow_offset = pwdata[9:0];
                else
                    shadow_gain = pwdata[15:0];
            end
        end
        quiet_cycles = busy ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("hall_flux_moving_average_top regression: fail");
            $finish;
        end
    end

    // Sends one sample, with random idle cycles before it at idle_pct.
    task automatic push_sample(input sample_t smp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, smp};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Holds the sender until every pending result has come back.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (LATENCY + 1) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready, then the bus goes
    // idle so that the next transfer starts on a later edge.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    // Default registers: the first WINDOW-1 means still count the cleared
    // entries, so they ramp up from the start-up state.
    task automatic test_startup_window();
        sample_t picks [7];
        picks = '{10'd0, 10'd1023, 10'd512, 10'd511, 10'd513, 10'h155, 10'h2AA};
        foreach (picks[i]) push_sample(picks[i]);
        drain_pipeline();
    endtask

    // Register extremes, upper pwdata bits that must be dropped, and the
    // floor rounding of small negative products.
    task automatic test_register_extremes();
        write_reg(REG_ZERO_OFFSET, 32'hFFFF_FC00);
        write_reg(REG_GAIN_Q16, 32'hABCD_FFFF);
        push_sample(10'd1023);
        push_sample(10'd0);
        drain_pipeline();
        write_reg(REG_ZERO_OFFSET, 32'h0000_03FF);
        push_sample(10'd0);
        push_sample(10'd1023);
        push_sample(10'd1022);
        drain_pipeline();
        write_reg(REG_GAIN_Q16, 32'h1234_0000);
        push_sample(10'd0);
        push_sample(10'd1023);
        drain_pipeline();
        write_reg(REG_GAIN_Q16, 32'h0000_0001);
        write_reg(REG_ZERO_OFFSET, 32'h0000_0201);
        push_sample(10'd512);
        push_sample(10'd514);
        push_sample(10'd0);
        drain_pipeline();
    endtask

    function automatic sample_t pick_offset();
        case ($urandom_range(5))
            0: return 10'd0;
            1: return 10'd1023;
            2: return ZERO_OFFSET_RST;
            default: return sample_t'($urandom_range(1023));
        endcase
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd65535;
            2: return GAIN_Q16_RST;
            default: return gain_t'($urandom_range(65535));
        endcase
    endfunction

    // Random traffic under four idling patterns, with fresh register values
    // written between segments while the pipeline is empty.
    task automatic test_random_traffic();
        int unsigned idle_set  [4];
        int unsigned stall_set [4];
        sample_t     offset;
        sample_t     smp;
        idle_set  = '{0, 54, 0, 14};
        stall_set = '{0, 0, 54, 14};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int seg = 0; seg < 3; seg++) begin
                offset = pick_offset();
                write_reg(REG_ZERO_OFFSET, {16'($urandom_range(65535)), 6'b0, offset});
                write_reg(REG_GAIN_Q16, {16'($urandom_range(65535)), pick_gain()});
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    case ($urandom_range(9))
                        0: smp = 10'd0;
                        1: smp = 10'd1023;
                        2: smp = offset + sample_t'($urandom_range(4)) - 10'd2;
                        default: smp = sample_t'($urandom_range(1023));
                    endcase
                    push_sample(smp);
                end
                drain_pipeline();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_startup_window();
        test_register_extremes();
        test_random_traffic();
        drain_pipeline();
        $display("covered %0d samples, %0d results, %0d register writes,",
                 samples_sent, readings_seen, reg_writes);
        $display("under four idle/stall patterns with register extremes and %0d errors",
                 mismatches);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("hall_flux_moving_average_top regression: pass");
        end else begin
            $display("hall_flux_moving_average_top regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/hfma_pkg.sv
rtl/core/hfma_ring.sv
rtl/core/hfma_mean_div.sv
rtl/core/hall_flux_moving_average_top.sv
bench/hall_flux_moving_average_top_tb.sv
